// ===== hdl/sacl_pkg.sv =====
`default_nettype none

package sacl_pkg;

   // Default geometry of the line memory
   localparam int MAX_SET_BITS_DEF = 6;
   localparam int MAX_WAYS_DEF     = 8;

   // Field widths
   localparam int ADDR_W  = 32;
   localparam int TAG_W   = 32;
   localparam int STAMP_W = 32;
   localparam int CNT_W   = 32;

   // Register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_SET_BITS   = 2'd0;
   localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
   localparam logic [1:0] REG_WAYS       = 2'd2;

   typedef enum logic [1:0] {
      MODE_LOAD,
      MODE_STORE,
      MODE_MODIFY,
      MODE_INSTR
   } mode_type;

   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_HIT,
      OUT_FILL,
      OUT_EVICT
   } outcome_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0] set_bits;
      logic [4:0] block_bits;
      logic [3:0] ways;
   } cfg_type;

   // Count up, stick at all ones
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] value);
      return (&value) ? value : value + CNT_W'(1);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/sacl_if.sv =====
`default_nettype none

interface sacl_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    mode;
   logic [sacl_pkg::ADDR_W-1:0]   address;

   modport source (output valid, output mode, output address, input ready);
   modport sink   (input valid, input mode, input address, output ready);
endinterface

interface sacl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    first_outcome;
   logic [1:0]                    second_outcome;
   logic [sacl_pkg::CNT_W-1:0]    hit_total;
   logic [sacl_pkg::CNT_W-1:0]    miss_total;
   logic [sacl_pkg::CNT_W-1:0]    evict_total;

   modport source (output valid, output first_outcome, output second_outcome,
                   output hit_total, output miss_total, output evict_total, input ready);
   modport sink   (input valid, input first_outcome, input second_outcome,
                   input hit_total, input miss_total, input evict_total, output ready);
endinterface

`default_nettype wire

// ===== hdl/sacl_csr.sv =====
`default_nettype none

module sacl_csr (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                psel,
   input  wire                                penable,
   input  wire                                pwrite,
   input  wire  [sacl_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire  [sacl_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [sacl_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output sacl_pkg::cfg_type                  cfg
);

   sacl_pkg::cfg_type cfg_ff;
   sacl_pkg::cfg_type cfg_in;
   logic [1:0]        reg_idx;

   assign reg_idx = paddr[sacl_pkg::CSR_ADDR_W-1:2];
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Take a write in the access phase
   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (reg_idx)
            sacl_pkg::REG_SET_BITS:   cfg_in.set_bits   = pwdata[2:0];
            sacl_pkg::REG_BLOCK_BITS: cfg_in.block_bits = pwdata[4:0];
            sacl_pkg::REG_WAYS:       cfg_in.ways       = pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_bits   <= 3'd0;
         cfg_ff.block_bits <= 5'd0;
         cfg_ff.ways       <= 4'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the selected register
   always_comb begin
      unique case (reg_idx)
         sacl_pkg::REG_SET_BITS:   prdata = sacl_pkg::CSR_DATA_W'(cfg_ff.set_bits);
         sacl_pkg::REG_BLOCK_BITS: prdata = sacl_pkg::CSR_DATA_W'(cfg_ff.block_bits);
         sacl_pkg::REG_WAYS:       prdata = sacl_pkg::CSR_DATA_W'(cfg_ff.ways);
         default:                  prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/sacl_set_ram.sv =====
`default_nettype none

module sacl_set_ram #(
   parameter  int ROWS  = 1 << sacl_pkg::MAX_SET_BITS_DEF,
   parameter  int ROW_W = sacl_pkg::MAX_WAYS_DEF
                          * (1 + sacl_pkg::TAG_W + sacl_pkg::STAMP_W),
   localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  wire              clock,
   input  wire              wr_en,
   input  wire  [IDX_W-1:0] wr_idx,
   input  wire  [ROW_W-1:0] wr_data,
   input  wire              rd_en,
   input  wire  [IDX_W-1:0] rd_idx,
   output logic [ROW_W-1:0] rd_data
);

   logic [ROW_W-1:0] mem_ff [ROWS];
   logic [ROW_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_idx];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sacl_lookup.sv =====
`default_nettype none

module sacl_lookup #(
   parameter  int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF,
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
   input  wire  [MAX_WAYS-1:0]                         valid,
   input  wire  [MAX_WAYS-1:0][sacl_pkg::TAG_W-1:0]    tags,
   input  wire  [MAX_WAYS-1:0][sacl_pkg::STAMP_W-1:0]  stamps,
   input  wire  [MAX_WAYS-1:0]                         in_use,
   input  wire  [sacl_pkg::TAG_W-1:0]                  tag,
   input  wire  [sacl_pkg::STAMP_W-1:0]                now,
   output logic                                        hit_found,
   output logic [WAY_W-1:0]                            hit_way,
   output logic                                        inv_found,
   output logic [WAY_W-1:0]                            inv_way,
   output logic [MAX_WAYS-1:0][sacl_pkg::STAMP_W-1:0]  ages
);

   // Lowest matching way wins, lowest empty way is filled first
   always_comb begin
      hit_found = 1'b0;
      hit_way   = '0;
      inv_found = 1'b0;
      inv_way   = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (in_use[w] && valid[w] && (tags[w] == tag)) begin
            hit_found = 1'b1;
            hit_way   = WAY_W'(w);
         end
         if (in_use[w] && !valid[w]) begin
            inv_found = 1'b1;
            inv_way   = WAY_W'(w);
         end
         // Ways outside the active count age as zero and never win
         ages[w] = in_use[w] ? (now - stamps[w]) : '0;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sacl_victim.sv =====
`default_nettype none

module sacl_victim #(
   parameter  int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF,
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
   localparam int LEAVES   = 1 << WAY_W,
   localparam int NODES    = 2 * LEAVES - 1
) (
   input  wire  [MAX_WAYS-1:0][sacl_pkg::STAMP_W-1:0] ages,
   output logic [WAY_W-1:0]                           victim
);

   logic [sacl_pkg::STAMP_W-1:0] node_age [NODES];
   logic [WAY_W-1:0]             node_way [NODES];

   // Leaves: one per way, padding ages zero
   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < MAX_WAYS) begin : g_used
         assign node_age[LEAVES-1+i] = ages[i];
      end else begin : g_pad
         assign node_age[LEAVES-1+i] = '0;
      end
      assign node_way[LEAVES-1+i] = WAY_W'(i);
   end

   // Oldest wins; on a tie keep the lower way (left child)
   for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
      assign node_age[n] = (node_age[2*n+2] > node_age[2*n+1]) ? node_age[2*n+2]
                                                               : node_age[2*n+1];
      assign node_way[n] = (node_age[2*n+2] > node_age[2*n+1]) ? node_way[2*n+2]
                                                               : node_way[2*n+1];
   end

   assign victim = node_way[0];

endmodule

`default_nettype wire

// ===== hdl/set_associative_cache_lru_model_core.sv =====
`default_nettype none

// Channel  Dir  Handshake      Payload
// req_bus  in   valid/ready    mode, address
// rsp_bus  out  valid/ready    first_outcome, second_outcome, hit/miss/evict totals
// csr_*    in   APB write/read set_bits @0x0, block_bits @0x4, ways @0x8
//
// A load or store is one access, a modify two and an instruction record none: each access is a
// look step on the registered set row and an update step that writes the row back.
// The second access of a modify works on the row held from the first, not a new read.
// After reset a clearing pass over all 2^MAX_SET_BITS rows (64 by default) empties the
// valid bits; no item is taken until it ends. A finished item waits in the output
// register while the next item is taken; only a further result stalls on rsp_bus.ready.

module set_associative_cache_lru_model_core #(
   parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   sacl_req_if.sink                            req_bus,
   sacl_rsp_if.source                          rsp_bus,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [sacl_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [sacl_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sacl_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int ROWS  = 1 << MAX_SET_BITS;
   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int ROW_W = MAX_WAYS * (1 + sacl_pkg::TAG_W + sacl_pkg::STAMP_W);
   localparam int TW    = sacl_pkg::TAG_W;
   localparam int SW    = sacl_pkg::STAMP_W;
   localparam int CW    = sacl_pkg::CNT_W;

   sacl_pkg::cfg_type cfg;

   // Control state
   sacl_pkg::state_type   state_ff, state_in;
   logic [SET_W-1:0]      clr_ff, clr_in;
   logic                  second_ff, second_in;
   logic [SW-1:0]         clock_ff, clock_in;
   logic [CW-1:0]         hits_ff, hits_in;
   logic [CW-1:0]         misses_ff, misses_in;
   logic [CW-1:0]         evicts_ff, evicts_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Item payload
   sacl_pkg::mode_type    mode_ff, mode_in;
   logic [TW-1:0]         tag_ff, tag_in;
   logic [SET_W-1:0]      set_ff, set_in;
   sacl_pkg::outcome_type first_ff, first_in;
   sacl_pkg::outcome_type second_out_ff, second_out_in;

   // Working row and lookup results
   logic [MAX_WAYS-1:0]          row_valid_ff, row_valid_in;
   logic [MAX_WAYS-1:0][TW-1:0]  row_tag_ff, row_tag_in;
   logic [MAX_WAYS-1:0][SW-1:0]  row_stamp_ff, row_stamp_in;
   logic                         hit_found_ff, hit_found_in;
   logic [WAY_W-1:0]             hit_way_ff, hit_way_in;
   logic                         inv_found_ff, inv_found_in;
   logic [WAY_W-1:0]             inv_way_ff, inv_way_in;
   logic [MAX_WAYS-1:0][SW-1:0]  ages_ff, ages_in;

   // Result register
   sacl_pkg::outcome_type rsp_first_ff, rsp_first_in;
   sacl_pkg::outcome_type rsp_second_ff, rsp_second_in;
   logic [CW-1:0]         rsp_hits_ff, rsp_hits_in;
   logic [CW-1:0]         rsp_misses_ff, rsp_misses_in;
   logic [CW-1:0]         rsp_evicts_ff, rsp_evicts_in;

   // Memory port
   logic                         wr_en, rd_en;
   logic [SET_W-1:0]             wr_idx, rd_idx;
   logic [ROW_W-1:0]             wr_data, rd_data;
   logic [MAX_WAYS-1:0]          rd_valid;
   logic [MAX_WAYS-1:0][TW-1:0]  rd_tag;
   logic [MAX_WAYS-1:0][SW-1:0]  rd_stamp;

   // Geometry
   logic [2:0]                   s_eff;
   logic [4:0]                   nw_eff;
   logic [5:0]                   tag_shift;
   logic [2*TW-1:0]              tag_wide;
   logic [sacl_pkg::ADDR_W-1:0]  blk_addr;
   logic [SET_W:0]               mask_wide;
   logic [TW-1:0]                req_tag;
   logic [SET_W-1:0]             req_set;
   logic [MAX_WAYS-1:0]          in_use;

   // Current row for lookup
   logic [MAX_WAYS-1:0]          cur_valid;
   logic [MAX_WAYS-1:0][TW-1:0]  cur_tag;
   logic [MAX_WAYS-1:0][SW-1:0]  cur_stamp;
   logic                         lk_hit_found, lk_inv_found;
   logic [WAY_W-1:0]             lk_hit_way, lk_inv_way;
   logic [MAX_WAYS-1:0][SW-1:0]  lk_ages;
   logic [WAY_W-1:0]             victim;
   logic [WAY_W-1:0]             sel_way;
   sacl_pkg::outcome_type        acc_out;

   sacl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   sacl_set_ram #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   assign {rd_valid, rd_tag, rd_stamp} = rd_data;

   // Clamp set bits and way count
   always_comb begin
      if (32'(cfg.set_bits) > 32'(MAX_SET_BITS)) begin
         s_eff = 3'(MAX_SET_BITS);
      end else begin
         s_eff = cfg.set_bits;
      end
      if (cfg.ways == 4'd0) begin
         nw_eff = 5'd1;
      end else if (32'(cfg.ways) > 32'(MAX_WAYS)) begin
         nw_eff = 5'(MAX_WAYS);
      end else begin
         nw_eff = {1'b0, cfg.ways};
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w] = (32'(w) < 32'(nw_eff));
      end
   end

   // Split the address; tag is zero once offset and set cover all bits
   assign tag_shift = {1'b0, cfg.block_bits} + {3'b000, s_eff};
   assign tag_wide  = {{TW{1'b0}}, req_bus.address} >> tag_shift;
   assign req_tag   = tag_wide[TW-1:0];
   assign blk_addr  = req_bus.address >> cfg.block_bits;
   assign mask_wide = ((SET_W+1)'(1) << s_eff) - (SET_W+1)'(1);
   assign req_set   = blk_addr[SET_W-1:0] & mask_wide[SET_W-1:0];

   // Second access of a modify reuses the row just written
   assign cur_valid = second_ff ? row_valid_ff : rd_valid;
   assign cur_tag   = second_ff ? row_tag_ff   : rd_tag;
   assign cur_stamp = second_ff ? row_stamp_ff : rd_stamp;

   sacl_lookup #(
      .MAX_WAYS (MAX_WAYS)
   ) u_lookup (
      .valid     (cur_valid),
      .tags      (cur_tag),
      .stamps    (cur_stamp),
      .in_use    (in_use),
      .tag       (tag_ff),
      .now       (clock_ff),
      .hit_found (lk_hit_found),
      .hit_way   (lk_hit_way),
      .inv_found (lk_inv_found),
      .inv_way   (lk_inv_way),
      .ages      (lk_ages)
   );

   sacl_victim #(
      .MAX_WAYS (MAX_WAYS)
   ) u_victim (
      .ages   (ages_ff),
      .victim (victim)
   );

   // Next state and datapath control
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      second_in     = second_ff;
      clock_in      = clock_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;
      evicts_in     = evicts_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      mode_in       = mode_ff;
      tag_in        = tag_ff;
      set_in        = set_ff;
      first_in      = first_ff;
      second_out_in = second_out_ff;
      row_valid_in  = row_valid_ff;
      row_tag_in    = row_tag_ff;
      row_stamp_in  = row_stamp_ff;
      hit_found_in  = hit_found_ff;
      hit_way_in    = hit_way_ff;
      inv_found_in  = inv_found_ff;
      inv_way_in    = inv_way_ff;
      ages_in       = ages_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_hits_in   = rsp_hits_ff;
      rsp_misses_in = rsp_misses_ff;
      rsp_evicts_in = rsp_evicts_ff;
      wr_en         = 1'b0;
      wr_idx        = set_ff;
      wr_data       = {row_valid_ff, row_tag_ff, row_stamp_ff};
      rd_en         = 1'b0;
      rd_idx        = req_set;
      sel_way       = victim;
      acc_out       = sacl_pkg::OUT_EVICT;
      req_bus.ready = 1'b0;

      unique case (state_ff)
         // Sweep the rows, dropping every valid bit
         sacl_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_idx  = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + SET_W'(1);
            if (clr_ff == SET_W'(ROWS - 1)) begin
               state_in = sacl_pkg::ST_IDLE;
            end
         end

         // Take an item and start the row read
         sacl_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               rd_en         = 1'b1;
               mode_in       = sacl_pkg::mode_type'(req_bus.mode);
               tag_in        = req_tag;
               set_in        = req_set;
               second_in     = 1'b0;
               first_in      = sacl_pkg::OUT_NONE;
               second_out_in = sacl_pkg::OUT_NONE;
               if (sacl_pkg::mode_type'(req_bus.mode) == sacl_pkg::MODE_INSTR) begin
                  state_in = sacl_pkg::ST_DONE;
               end else begin
                  state_in = sacl_pkg::ST_LOOK;
               end
            end
         end

         // Compare tags, find an empty way, compute ages
         sacl_pkg::ST_LOOK: begin
            row_valid_in = cur_valid;
            row_tag_in   = cur_tag;
            row_stamp_in = cur_stamp;
            hit_found_in = lk_hit_found;
            hit_way_in   = lk_hit_way;
            inv_found_in = lk_inv_found;
            inv_way_in   = lk_inv_way;
            ages_in      = lk_ages;
            state_in     = sacl_pkg::ST_UPDATE;
         end

         // Stamp or replace one way and write the row back
         sacl_pkg::ST_UPDATE: begin
            priority if (hit_found_ff) begin
               sel_way = hit_way_ff;
               acc_out = sacl_pkg::OUT_HIT;
               hits_in = sacl_pkg::sat_inc(hits_ff);
            end else if (inv_found_ff) begin
               sel_way   = inv_way_ff;
               acc_out   = sacl_pkg::OUT_FILL;
               misses_in = sacl_pkg::sat_inc(misses_ff);
            end else begin
               sel_way   = victim;
               acc_out   = sacl_pkg::OUT_EVICT;
               misses_in = sacl_pkg::sat_inc(misses_ff);
               evicts_in = sacl_pkg::sat_inc(evicts_ff);
            end
            row_valid_in[sel_way] = 1'b1;
            row_tag_in[sel_way]   = tag_ff;
            row_stamp_in[sel_way] = clock_ff;
            wr_en   = 1'b1;
            wr_idx  = set_ff;
            wr_data = {row_valid_in, row_tag_in, row_stamp_in};
            if (second_ff) begin
               second_out_in = acc_out;
            end else begin
               first_in = acc_out;
            end
            if ((mode_ff == sacl_pkg::MODE_MODIFY) && !second_ff) begin
               second_in = 1'b1;
               state_in  = sacl_pkg::ST_LOOK;
            end else begin
               clock_in = clock_ff + SW'(1);
               state_in = sacl_pkg::ST_DONE;
            end
         end

         // Hand the item to the output register once it is free
         sacl_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_first_in  = first_ff;
               rsp_second_in = second_out_ff;
               rsp_hits_in   = hits_ff;
               rsp_misses_in = misses_ff;
               rsp_evicts_in = evicts_ff;
               state_in      = sacl_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sacl_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sacl_pkg::ST_CLEAR;
         clr_ff       <= '0;
         second_ff    <= 1'b0;
         clock_ff     <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evicts_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         second_ff    <= second_in;
         clock_ff     <= clock_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         evicts_ff    <= evicts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      tag_ff        <= tag_in;
      set_ff        <= set_in;
      first_ff      <= first_in;
      second_out_ff <= second_out_in;
      row_valid_ff  <= row_valid_in;
      row_tag_ff    <= row_tag_in;
      row_stamp_ff  <= row_stamp_in;
      hit_found_ff  <= hit_found_in;
      hit_way_ff    <= hit_way_in;
      inv_found_ff  <= inv_found_in;
      inv_way_ff    <= inv_way_in;
      ages_ff       <= ages_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_hits_ff   <= rsp_hits_in;
      rsp_misses_ff <= rsp_misses_in;
      rsp_evicts_ff <= rsp_evicts_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.first_outcome  = rsp_first_ff;
   assign rsp_bus.second_outcome = rsp_second_ff;
   assign rsp_bus.hit_total      = rsp_hits_ff;
   assign rsp_bus.miss_total     = rsp_misses_ff;
   assign rsp_bus.evict_total    = rsp_evicts_ff;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
   import sacl_pkg::*;

   localparam int SET_SLOTS   = 1 << MAX_SET_BITS_DEF;
   localparam int LINE_SLOTS  = SET_SLOTS * MAX_WAYS_DEF;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 170;

   typedef struct packed {
      outcome_type      first_outcome;
      outcome_type      second_outcome;
      logic [CNT_W-1:0] hit_total;
      logic [CNT_W-1:0] miss_total;
      logic [CNT_W-1:0] evict_total;
   } tally_type;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sacl_req_if req_bus ();
   sacl_rsp_if rsp_bus ();

   set_associative_cache_lru_model_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Cache image kept by the testbench
   logic [2:0]         geo_set_bits   = 3'd0;
   logic [4:0]         geo_block_bits = 5'd0;
   logic [3:0]         geo_ways       = 4'd1;
   bit                 line_filled [LINE_SLOTS];
   logic [TAG_W-1:0]   line_tag_copy [LINE_SLOTS];
   logic [STAMP_W-1:0] line_stamp_copy [LINE_SLOTS];
   logic [31:0]        trace_clock = '0;
   logic [CNT_W-1:0]   hit_count   = '0;
   logic [CNT_W-1:0]   miss_count  = '0;
   logic [CNT_W-1:0]   evict_count = '0;

   tally_type pending_tallies[$];
   int        errors       = 0;
   bit        steady_flow  = 1'b0;
   int        burst_left   = 0;
   int        stall_orders = 0;
   int        stall_served = 0;
   int        hold_left    = 0;
   int        ready_pattern = 0;
   int        pattern_left  = 0;

   function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] value);
      return (value == '1) ? value : value + 1'b1;
   endfunction

   function automatic int eff_set_bits();
      return (int'(geo_set_bits) > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(geo_set_bits);
   endfunction

   function automatic int eff_ways();
      if (geo_ways == 4'd0) return 1;
      return (int'(geo_ways) > MAX_WAYS_DEF) ? MAX_WAYS_DEF : int'(geo_ways);
   endfunction

   // One lookup: hit, fill of the first empty way, or eviction of the oldest way
   function automatic outcome_type cache_access(input logic [ADDR_W-1:0] address);
      int          s;
      int          nw;
      int          base;
      int          victim;
      logic [63:0] wide;
      logic [31:0] tag;
      logic [31:0] set_idx;
      logic [31:0] oldest;
      logic [31:0] age;
      s       = eff_set_bits();
      nw      = eff_ways();
      wide    = {32'd0, address};
      tag     = 32'(wide >> (int'(geo_block_bits) + s));
      set_idx = 32'(wide >> geo_block_bits) & ((32'd1 << s) - 32'd1);
      base    = int'(set_idx) * MAX_WAYS_DEF;
      for (int w = 0; w < nw; w++) begin
         if (line_filled[base + w] && line_tag_copy[base + w] == tag) begin
            hit_count = count_up(hit_count);
            line_stamp_copy[base + w] = trace_clock;
            return OUT_HIT;
         end
      end
      miss_count = count_up(miss_count);
      for (int w = 0; w < nw; w++) begin
         if (!line_filled[base + w]) begin
            line_filled[base + w]     = 1'b1;
            line_tag_copy[base + w]   = tag;
            line_stamp_copy[base + w] = trace_clock;
            return OUT_FILL;
         end
      end
      evict_count = count_up(evict_count);
      victim = 0;
      oldest = '0;
      for (int w = 0; w < nw; w++) begin
         age = trace_clock - line_stamp_copy[base + w];
         if (age > oldest) begin
            oldest = age;
            victim = w;
         end
      end
      line_tag_copy[base + victim]   = tag;
      line_stamp_copy[base + victim] = trace_clock;
      return OUT_EVICT;
   endfunction

   function automatic tally_type predict_record(input mode_type mode,
                                                input logic [ADDR_W-1:0] address);
      tally_type t;
      t.first_outcome  = OUT_NONE;
      t.second_outcome = OUT_NONE;
      if (mode != MODE_INSTR) begin
         t.first_outcome = cache_access(address);
         if (mode == MODE_MODIFY) t.second_outcome = cache_access(address);
         trace_clock = trace_clock + 1'b1;
      end
      t.hit_total   = hit_count;
      t.miss_total  = miss_count;
      t.evict_total = evict_count;
      return t;
   endfunction

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         errors++;
      end
   endtask

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_results
      tally_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_tallies.size() == 0) begin
            $display("%0t: unexpected result, expected nothing, actual %0h/%0h", $time,
                     rsp_bus.first_outcome, rsp_bus.second_outcome);
            errors++;
         end else begin
            want = pending_tallies.pop_front();
            check_field("first_outcome", 32'(want.first_outcome), 32'(rsp_bus.first_outcome));
            check_field("second_outcome", 32'(want.second_outcome),
                        32'(rsp_bus.second_outcome));
            check_field("hit_total", want.hit_total, rsp_bus.hit_total);
            check_field("miss_total", want.miss_total, rsp_bus.miss_total);
            check_field("evict_total", want.evict_total, rsp_bus.evict_total);
         end
      end
   end

   // Result side: long hold on request, otherwise switch among ready patterns
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
         pattern_left  <= 0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (stall_served != stall_orders) begin
         stall_served  <= stall_orders;
         hold_left     <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            ready_pattern <= $urandom_range(0, 3);
            pattern_left  <= $urandom_range(10, 120);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         case (ready_pattern)
            0: begin
               rsp_bus.ready <= 1'b1;
            end
            1: begin
               rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
               rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_bus.ready <= ~rsp_bus.ready;
            end
         endcase
      end
   end

   // Offer one item, record its expectation on acceptance, then maybe idle
   task automatic send_item(input mode_type mode, input logic [ADDR_W-1:0] address);
      int gap;
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= mode;
      req_bus.address <= address;
      do @(posedge clock); while (!req_bus.ready);
      pending_tallies.push_back(predict_record(mode, address));
      if (steady_flow) return;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 15);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drop valid and hold until every expected result has come
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_tallies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({index, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_SET_BITS: begin
            geo_set_bits = value[2:0];
         end
         REG_BLOCK_BITS: begin
            geo_block_bits = value[4:0];
         end
         REG_WAYS: begin
            geo_ways = value[3:0];
         end
         default: begin
         end
      endcase
   endtask

   // Read a register, sampling read data mid-cycle in the access phase
   task automatic csr_check(input logic [1:0] index, input logic [CSR_DATA_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'({index, 2'b00});
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         got = csr_prdata;
         @(posedge clock);
      end while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      check_field("register readback", want, got);
   endtask

   // Change the geometry once the block is idle, and read it back
   task automatic apply_geometry(input logic [2:0] s, input logic [4:0] b,
                                 input logic [3:0] w);
      wait_drained();
      csr_write(REG_SET_BITS, 32'(s));
      csr_write(REG_BLOCK_BITS, 32'(b));
      csr_write(REG_WAYS, 32'(w));
      csr_check(REG_SET_BITS, 32'(s));
      csr_check(REG_BLOCK_BITS, 32'(b));
      csr_check(REG_WAYS, 32'(w));
   endtask

   // Address built from a small pool of tags so that sets hit and evict
   function automatic logic [ADDR_W-1:0] pooled_address();
      int          s;
      int          b;
      logic [63:0] wide;
      logic [63:0] set_idx;
      logic [63:0] tag;
      s       = eff_set_bits();
      b       = int'(geo_block_bits);
      tag     = 64'($urandom_range(0, eff_ways() + 2));
      set_idx = ($urandom_range(0, 3) == 0) ? 64'($urandom) : 64'($urandom_range(0, 2));
      set_idx = set_idx & ((64'd1 << s) - 64'd1);
      wide    = (tag << (b + s)) | (set_idx << b) | (64'($urandom) & ((64'd1 << b) - 64'd1));
      return wide[ADDR_W-1:0];
   endfunction

   task automatic send_random(output bit counted);
      int                pick;
      mode_type          mode;
      logic [ADDR_W-1:0] address;
      pick    = $urandom_range(0, 99);
      mode    = (pick < 8) ? MODE_INSTR : mode_type'($urandom_range(0, 2));
      address = (pick < 16) ? ADDR_W'($urandom) : pooled_address();
      counted = (mode != MODE_INSTR);
      send_item(mode, address);
   endtask

   // Reset geometry: one way, one set, byte lines
   task automatic test_reset_defaults();
      csr_check(REG_SET_BITS, 32'd0);
      csr_check(REG_BLOCK_BITS, 32'd0);
      csr_check(REG_WAYS, 32'd1);
      send_item(MODE_LOAD, 32'h0000_0000);
      send_item(MODE_LOAD, 32'h0000_0000);
      send_item(MODE_INSTR, 32'hFFFF_FFFF);
      send_item(MODE_STORE, 32'hFFFF_FFFF);
      send_item(MODE_MODIFY, 32'h1234_5678);
      send_item(MODE_MODIFY, 32'h1234_5678);
   endtask

   // Two ways, two sets: fills, hits and least-recently-used victims
   task automatic test_lru_order();
      apply_geometry(3'd1, 5'd4, 4'd2);
      send_item(MODE_LOAD, 32'h0000_0020);
      send_item(MODE_LOAD, 32'h0000_0040);
      send_item(MODE_LOAD, 32'h0000_002F);
      send_item(MODE_STORE, 32'h0000_0060);
      send_item(MODE_LOAD, 32'h0000_0040);
      send_item(MODE_LOAD, 32'h0000_0061);
      send_item(MODE_LOAD, 32'h0000_0030);
   endtask

   // Oversized set bits, out-of-range ways, wide offsets, lines kept over changes
   task automatic test_special_geometry();
      apply_geometry(3'd7, 5'd31, 4'd15);
      send_item(MODE_LOAD, 32'hFFFF_FFFF);
      send_item(MODE_LOAD, 32'h7FFF_FFFF);
      send_item(MODE_LOAD, 32'h8000_0000);
      apply_geometry(3'd6, 5'd26, 4'd0);
      send_item(MODE_STORE, 32'hFC00_0000);
      send_item(MODE_MODIFY, 32'h0400_0000);
      apply_geometry(3'd0, 5'd0, 4'd8);
      send_item(MODE_LOAD, 32'h0000_0005);
      send_item(MODE_LOAD, 32'hDEAD_BEEF);
      send_item(MODE_INSTR, 32'h0000_0000);
   endtask

   // Hold the result side off while items keep coming, then drain
   task automatic test_backpressure();
      bit counted;
      apply_geometry(3'd2, 5'd3, 4'd4);
      stall_orders <= stall_orders + 1;
      steady_flow = 1'b1;
      repeat (40) send_random(counted);
      steady_flow = 1'b0;
      wait_drained();
   endtask

   // Random traffic over a run of geometries, extremes included
   task automatic test_random_traffic();
      logic [2:0] s_list [8];
      logic [4:0] b_list [8];
      logic [3:0] w_list [8];
      int         done;
      bit         counted;
      s_list = '{3'd0, 3'd6, 3'd7, 3'd2, 3'd1, 3'd3, 3'd0, 3'd0};
      b_list = '{5'd0, 5'd26, 5'd31, 5'd4, 5'd2, 5'd6, 5'd0, 5'd0};
      w_list = '{4'd1, 4'd8, 4'd15, 4'd4, 4'd0, 4'd9, 4'd0, 4'd0};
      for (int p = 0; p < 8; p++) begin
         if (p >= 6) begin
            s_list[p] = 3'($urandom);
            b_list[p] = 5'($urandom);
            w_list[p] = 4'($urandom);
         end
         apply_geometry(s_list[p], b_list[p], w_list[p]);
         done = 0;
         while (done < PHASE_ITEMS) begin
            send_random(counted);
            if (counted) done++;
         end
      end
   endtask

   initial begin
      reset           <= 1'b1;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.mode    <= MODE_LOAD;
      req_bus.address <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_lru_order();
      test_special_geometry();
      test_backpressure();
      test_random_traffic();
      wait_drained();
      if (errors == 0 && pending_tallies.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #1000000;
      $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
